// ===== rtl/core/tgsf_pkg.sv =====
// Package for the text grid store: codes, queue entry type and defaults.
package tgsf_pkg;

  localparam int DEF_COLS    = 64;
  localparam int DEF_ROWS    = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FILL
  } back_state_t;

  // Classified command; positions are 0-based, last_* bound the rectangle.
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [7:0] col0;
    logic [7:0] row0;
    logic [7:0] last_col;
    logic [7:0] last_row;
  } cmd_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// ===== rtl/core/tgsf_front.sv =====
// Front end: bounds checking and classification of one command.
module tgsf_front #(
  parameter int COLS   = tgsf_pkg::DEF_COLS,
  parameter int ROWS   = tgsf_pkg::DEF_ROWS,
  parameter int ADDR_W = 11
) (
  input  logic [1:0]            command,
  input  logic [7:0]            ch,
  input  logic [7:0]            col,
  input  logic [7:0]            row,
  input  logic [7:0]            fill_width,
  input  logic [7:0]            fill_height,
  output tgsf_pkg::cmd_entry_t  entry,
  output logic [ADDR_W-1:0]     start_addr
);

  logic [8:0]  col9, row9, col_end9, row_end9;
  logic        cell_ok, fill_ok;
  logic [7:0]  col0, row0;
  logic [15:0] base16;

  assign col9     = {1'b0, col};
  assign row9     = {1'b0, row};
  assign col_end9 = col9 + {1'b0, fill_width};
  assign row_end9 = row9 + {1'b0, fill_height};

  assign cell_ok = (col != 8'd0) && (col9 <= 9'(COLS)) &&
                   (row != 8'd0) && (row9 <= 9'(ROWS));
  assign fill_ok = cell_ok && (fill_width != 8'd0) && (fill_height != 8'd0) &&
                   (col_end9 <= 9'(COLS + 1)) && (row_end9 <= 9'(ROWS + 1));

  assign col0 = col - 8'd1;
  assign row0 = row - 8'd1;

  // row-major cell address of the corner
  assign base16     = 16'(row0) * 16'(COLS) + 16'(col0);
  assign start_addr = base16[ADDR_W-1:0];

  always_comb begin
    entry          = '0;
    entry.ch       = ch;
    entry.col0     = col0;
    entry.row0     = row0;
    entry.last_col = col0;
    entry.last_row = row0;
    case (command)
      tgsf_pkg::CMD_SET: begin
        entry.op = cell_ok ? tgsf_pkg::OP_WRITE : tgsf_pkg::OP_REJECT;
      end
      tgsf_pkg::CMD_FILL: begin
        entry.op       = fill_ok ? tgsf_pkg::OP_WRITE : tgsf_pkg::OP_REJECT;
        entry.last_col = 8'(col_end9 - 9'd2);
        entry.last_row = 8'(row_end9 - 9'd2);
      end
      tgsf_pkg::CMD_READ: begin
        entry.op = cell_ok ? tgsf_pkg::OP_READ : tgsf_pkg::OP_REJECT;
      end
      default: begin
        entry.op = tgsf_pkg::OP_REJECT;
      end
    endcase
  end

endmodule

// ===== rtl/core/tgsf_queue.sv =====
// Short command queue between the front end and the execution engine.
module tgsf_queue #(
  parameter int DATA_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_W-1:0]     din,
  input  logic                  pop,
  output logic [DATA_W-1:0]     dout,
  output tgsf_pkg::queue_stat_t stat
);

  localparam int DEPTH = tgsf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign dout       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/tgsf_back.sv =====
// Execution engine: grid memory, clearing sweep, cell writes, fills and reads.
module tgsf_back #(
  parameter int COLS   = tgsf_pkg::DEF_COLS,
  parameter int ROWS   = tgsf_pkg::DEF_ROWS,
  parameter int ADDR_W = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  tgsf_pkg::cmd_entry_t head,
  input  logic [ADDR_W-1:0]    head_addr,
  output logic                 pop,
  output logic                 clearing,
  output logic                 res_strobe,
  output logic                 res_status,
  output logic [7:0]           res_read_char
);

  localparam int DEPTH = COLS * ROWS;

  logic [7:0] grid_mem [DEPTH];

  tgsf_pkg::back_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt, line_r, line_nxt;
  logic [7:0]        col_r, col_nxt, row_r, row_nxt;
  logic [7:0]        c0_r, lc_r, lr_r, ch_r;
  logic              strobe_r, strobe_nxt, status_r, status_nxt;
  logic              is_read_r, is_read_nxt;
  logic [7:0]        rd_data_r;

  logic [ADDR_W-1:0] cur_addr, cur_line;
  logic [7:0]        cur_col, cur_row, cur_c0, cur_lc, cur_lr, cur_ch;
  logic              clr_last, is_last, take_write, take_read, take_reject;
  logic              mem_we, mem_re, fill_active;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign clr_last    = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign pop         = (state_r == tgsf_pkg::BK_IDLE) && head_valid;
  assign take_write  = pop && (head.op == tgsf_pkg::OP_WRITE);
  assign take_read   = pop && (head.op == tgsf_pkg::OP_READ);
  assign take_reject = pop && (head.op != tgsf_pkg::OP_WRITE) &&
                       (head.op != tgsf_pkg::OP_READ);
  assign fill_active = (state_r == tgsf_pkg::BK_FILL);
  assign clearing    = (state_r == tgsf_pkg::BK_CLEAR);

  // current cell: straight from the queue head on the first beat, else held
  always_comb begin
    if (fill_active) begin
      cur_addr = addr_r;
      cur_line = line_r;
      cur_col  = col_r;
      cur_row  = row_r;
      cur_c0   = c0_r;
      cur_lc   = lc_r;
      cur_lr   = lr_r;
      cur_ch   = ch_r;
    end else begin
      cur_addr = head_addr;
      cur_line = head_addr - ADDR_W'(head.col0);
      cur_col  = head.col0;
      cur_row  = head.row0;
      cur_c0   = head.col0;
      cur_lc   = head.last_col;
      cur_lr   = head.last_row;
      cur_ch   = head.ch;
    end
  end

  assign is_last = (cur_col == cur_lc) && (cur_row == cur_lr);

  // step to the next cell, wrapping to the left column of the next line
  always_comb begin
    if (cur_col == cur_lc) begin
      col_nxt  = cur_c0;
      row_nxt  = cur_row + 8'd1;
      line_nxt = cur_line + ADDR_W'(COLS);
      addr_nxt = cur_line + ADDR_W'(COLS) + ADDR_W'(cur_c0);
    end else begin
      col_nxt  = cur_col + 8'd1;
      row_nxt  = cur_row;
      line_nxt = cur_line;
      addr_nxt = cur_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgsf_pkg::BK_CLEAR: begin
        if (clr_last) begin
          state_nxt = tgsf_pkg::BK_IDLE;
        end
      end
      tgsf_pkg::BK_IDLE: begin
        if (take_write && !is_last) begin
          state_nxt = tgsf_pkg::BK_FILL;
        end
      end
      tgsf_pkg::BK_FILL: begin
        if (is_last) begin
          state_nxt = tgsf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tgsf_pkg::BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cur_addr;
    mem_wdata    = cur_ch;
    clr_addr_nxt = clr_addr_r;
    strobe_nxt   = 1'b0;
    status_nxt   = 1'b0;
    is_read_nxt  = 1'b0;
    case (state_r)
      tgsf_pkg::BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = 8'd0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      tgsf_pkg::BK_IDLE: begin
        mem_we      = take_write;
        mem_re      = take_read;
        strobe_nxt  = take_read || take_reject || (take_write && is_last);
        status_nxt  = take_reject;
        is_read_nxt = take_read;
      end
      tgsf_pkg::BK_FILL: begin
        mem_we     = 1'b1;
        strobe_nxt = is_last;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tgsf_pkg::BK_CLEAR;
      clr_addr_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    is_read_r <= is_read_nxt;
    addr_r    <= addr_nxt;
    line_r    <= line_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    if (take_write) begin
      c0_r <= head.col0;
      lc_r <= head.last_col;
      lr_r <= head.last_row;
      ch_r <= head.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[cur_addr];
    end
  end

  assign res_strobe    = strobe_r;
  assign res_status    = status_r;
  assign res_read_char = is_read_r ? rd_data_r : 8'd0;

endmodule

// ===== rtl/core/text_grid_set_and_fill_core.sv =====
// Top level of the text grid store: front end, command queue and engine.
// Results are registered and show in the cycle after a set, read or rejected
// command leaves the queue; each accepted command is first written into the queue.
// Throughput: one set, read or rejected command per cycle while no fill runs; a
// fill holds the engine, writing one rectangle cell per cycle on the single write port.
// Reset: synchronous; afterwards a clearing sweep zeroes all COLS*ROWS cells,
// one a cycle, with busy high. Results carry no back-pressure.
module text_grid_set_and_fill_core #(
  parameter int COLS = tgsf_pkg::DEF_COLS,
  parameter int ROWS = tgsf_pkg::DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_ch,
  input  logic [7:0] in_col,
  input  logic [7:0] in_row,
  input  logic [7:0] in_fill_width,
  input  logic [7:0] in_fill_height,
  output logic       out_strobe,
  output logic       out_status,
  output logic [7:0] out_read_char
);

  localparam int CELLS   = COLS * ROWS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ENTRY_W = $bits(tgsf_pkg::cmd_entry_t);
  localparam int Q_W     = ENTRY_W + ADDR_W;

  tgsf_pkg::cmd_entry_t  fe_entry, hd_entry;
  tgsf_pkg::queue_stat_t q_stat;
  logic [ADDR_W-1:0]     fe_addr, hd_addr;
  logic [Q_W-1:0]        q_din, q_dout;
  logic                  accept, q_pop, clearing;

  // Take a beat whenever the queue has room and the sweep is done.
  assign busy   = q_stat.full || clearing;
  assign accept = start && !busy;

  tgsf_front #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_front (
    .command     (in_command),
    .ch          (in_ch),
    .col         (in_col),
    .row         (in_row),
    .fill_width  (in_fill_width),
    .fill_height (in_fill_height),
    .entry       (fe_entry),
    .start_addr  (fe_addr)
  );

  // Pack the classified command with its start address.
  assign q_din = {fe_addr, fe_entry};

  tgsf_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  assign hd_entry = q_dout[ENTRY_W-1:0];
  assign hd_addr  = q_dout[Q_W-1:ENTRY_W];

  tgsf_back #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (!q_stat.empty),
    .head          (hd_entry),
    .head_addr     (hd_addr),
    .pop           (q_pop),
    .clearing      (clearing),
    .res_strobe    (out_strobe),
    .res_status    (out_status),
    .res_read_char (out_read_char)
  );

  // The sweep blocks new beats and produces no results.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (busy && !out_strobe))
    else $error("result or accept during clearing sweep");

  // A rejected command never returns data.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (out_read_char == 8'd0))
    else $error("rejected command returned a character");

  // The engine only drains a queue that holds something.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  // Every read or rejected pop yields a result; fills are not checked here.
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (hd_entry.op != tgsf_pkg::OP_WRITE)) |=> out_strobe)
    else $error("read or reject without a result");

endmodule
